[src/bpra_pkg.sv]
// Shared constants, types and beat structs for the bitmap page run allocator.
// Depends on nothing; every other file of the block imports it.

package bpra_pkg;

  // Heap geometry.
  localparam int unsigned MAX_PAGES  = 4096;
  localparam int unsigned PAGE_BYTES = 4096;

  // Field widths fixed by the interface.
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned COUNT_W = 13;

  // Page index and page count widths that follow from the heap size.
  localparam int unsigned PIDX_W = $clog2(MAX_PAGES);
  localparam int unsigned LIM_W  = PIDX_W + 1;
  localparam int unsigned CNT_W  = (LIM_W > COUNT_W) ? LIM_W : COUNT_W;

  // Bitmap words: 32 pages per word, at least two words for tiny heaps.
  localparam int unsigned WORD_BITS = (MAX_PAGES >= 64) ? 32 : MAX_PAGES / 2;
  localparam int unsigned WB_W      = $clog2(WORD_BITS);
  localparam int unsigned NUM_WORDS = MAX_PAGES / WORD_BITS;
  localparam int unsigned WADDR_W   = $clog2(NUM_WORDS);

  // Address to page conversion.
  localparam int unsigned PB_SH = $clog2(PAGE_BYTES);
  localparam int unsigned PG_W  = ADDR_W - PB_SH;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_PAGES = 1'b0,
    REG_HEAP_BASE  = 1'b1
  } cfg_reg_e;

  // Operation codes of an input beat.
  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_e;

  // Bitmap read request.
  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
  } bm_rd_t;

  // Bitmap write request.
  typedef struct packed {
    logic                 en;
    logic [WADDR_W-1:0]   addr;
    logic [WORD_BITS-1:0] data;
  } bm_wr_t;

  // Outcome of scanning one bitmap word.
  typedef struct packed {
    logic             hit;
    logic [WB_W-1:0]  pos;
    logic [CNT_W-1:0] run_out;
  } scan_res_t;

endpackage

[src/bitmap_page_run_allocator.sv]
// Top level of the bitmap page run allocator: command port, configuration
// registers and the sequencer that scans and updates the page bitmap.
// Depends on bpra_pkg, bpra_bitmap and bpra_word_scan.
//
// Usage: a command beat (mode_i, page_count_i, free_address_i) is taken at a
// clock edge where start is high and busy is low. Every command gives exactly
// one result beat on run_address_o and success_o, marked by done_o for one
// cycle; the receiver cannot hold it off. The next command can be taken in
// the cycle the result is shown.
// An allocate reads the bitmap one 32-page word per cycle from page 0 up to
// the first fitting run, then rewrites the words of that run one per cycle.
// A zero count or an empty heap fails without reading the bitmap; any other
// failed allocate ends after the word that holds the last page of the heap.
// A free does its address arithmetic in the states S_FSUB, S_FEND and S_FCLIP
// and reads the first word of the range, then rewrites one bitmap word per
// cycle; it ends after S_FCLIP when no page of the range lies in the heap.
// The single bitmap port pair sets this pace.
// Reset clears the configuration registers and control flags, returns the
// sequencer to idle and marks every page free at once through per-word valid
// bits; no clearing pass is needed.
// Configuration writes belong in idle time only.

module bitmap_page_run_allocator
  import bpra_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i,
  // Command port.
  input  logic                 start,
  output logic                 busy,
  input  logic                 mode_i,
  input  logic [COUNT_W-1:0]   page_count_i,
  input  logic [ADDR_W-1:0]    free_address_i,
  // Result port.
  output logic                 done_o,
  output logic [ADDR_W-1:0]    run_address_o,
  output logic                 success_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_WSTART = 7'b0000100,
    S_WALK   = 7'b0001000,
    S_FSUB   = 7'b0010000,
    S_FEND   = 7'b0100000,
    S_FCLIP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [COUNT_W-1:0] heap_pages_q;
  logic [ADDR_W-1:0]  heap_base_q;

  // Command registers.
  mode_e              mode_q, mode_d;
  logic [CNT_W-1:0]   want_q, want_d;
  logic [ADDR_W-1:0]  faddr_q, faddr_d;

  // Scan and walk registers.
  logic [WADDR_W-1:0] issue_w_q, issue_w_d;
  logic               issue_ok_q, issue_ok_d;
  logic [CNT_W-1:0]   run_q, run_d;
  logic               rd_ok_q, rd_ok_d;
  logic [WADDR_W-1:0] rd_w_q, rd_w_d;
  logic [PIDX_W-1:0]  lo_q, lo_d;
  logic [LIM_W-1:0]   hi_q, hi_d;

  // Free range arithmetic.
  logic [PG_W-1:0]    page0_q, page0_d;
  logic [PG_W:0]      end_q, end_d;

  // Result registers.
  logic               done_q, done_d;
  logic [ADDR_W-1:0]  res_addr_q, res_addr_d;
  logic               res_ok_q, res_ok_d;

  // Bitmap and scanner connections.
  bm_rd_t               bm_rd;
  bm_wr_t               bm_wr;
  logic [WORD_BITS-1:0] bm_rdata;
  logic [WORD_BITS-1:0] scan_used;
  scan_res_t            scan_res;

  // Heap limit and its last word.
  logic [LIM_W-1:0]   limit;
  logic [LIM_W-1:0]   limit_m1;
  logic [WADDR_W-1:0] last_w;
  logic [WB_W-1:0]    last_bit;

  // Walk range decode.
  logic [LIM_W-1:0]     hi_m1;
  logic [WADDR_W-1:0]   lo_word;
  logic [WADDR_W-1:0]   hi_word;
  logic [WB_W-1:0]      lo_bit;
  logic [WB_W-1:0]      hi_bit;
  logic [WORD_BITS-1:0] walk_mask;

  // Hit position decode.
  logic [PIDX_W-1:0]  hit_page;
  logic [PIDX_W-1:0]  hit_start;

  // Free range clipping.
  logic [PG_W-1:0]    clip_lo;
  logic [PG_W-1:0]    clip_hi;
  logic [PG_W-1:0]    limit_pg;
  logic [ADDR_W-1:0]  fdiff;

  assign busy = (state_q != S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_pages_q <= '0;
      heap_base_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HEAP_PAGES: heap_pages_q <= cfg_wdata_i[COUNT_W-1:0];
        REG_HEAP_BASE:  heap_base_q  <= cfg_wdata_i;
        default:        heap_base_q  <= heap_base_q;
      endcase
    end
  end

  // Usable page count and the bitmap word that holds the last usable page.
  assign limit    = (32'(heap_pages_q) > 32'(MAX_PAGES)) ? LIM_W'(MAX_PAGES)
                                                        : LIM_W'(heap_pages_q);
  assign limit_m1 = limit - LIM_W'(1);
  assign last_w   = limit_m1[PIDX_W-1:WB_W];
  assign last_bit = limit_m1[WB_W-1:0];

  // Pages at or above the limit count as used while scanning.
  always_comb begin
    scan_used = bm_rdata;
    if (rd_w_q == last_w) begin
      for (int j = 0; j < WORD_BITS; j++) begin
        if (WB_W'(j) > last_bit) begin
          scan_used[j] = 1'b1;
        end
      end
    end
  end

  bpra_word_scan u_scan (
    .used_i (scan_used),
    .run_i  (run_q),
    .want_i (want_q),
    .res_o  (scan_res)
  );

  // Page where the run completes and the page where it starts.
  assign hit_page  = {rd_w_q, scan_res.pos};
  assign hit_start = hit_page + PIDX_W'(1) - PIDX_W'(want_q);

  // Bits of the current walk word that fall inside [lo, hi).
  assign hi_m1     = hi_q - LIM_W'(1);
  assign lo_word   = lo_q[PIDX_W-1:WB_W];
  assign hi_word   = hi_m1[PIDX_W-1:WB_W];
  assign lo_bit    = (rd_w_q == lo_word) ? lo_q[WB_W-1:0] : '0;
  assign hi_bit    = (rd_w_q == hi_word) ? hi_m1[WB_W-1:0] : WB_W'(WORD_BITS - 1);
  assign walk_mask = ({WORD_BITS{1'b1}} << lo_bit)
                   & ({WORD_BITS{1'b1}} >> (WB_W'(WORD_BITS - 1) - hi_bit));

  // Free range: page index wraps with the address, only pages below the
  // limit survive the clip.
  assign fdiff    = faddr_q - heap_base_q;
  assign limit_pg = PG_W'(limit);
  assign clip_lo  = end_q[PG_W] ? '0 : page0_q;
  assign clip_hi  = (end_q[PG_W-1:0] < limit_pg) ? end_q[PG_W-1:0] : limit_pg;

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    want_d     = want_q;
    faddr_d    = faddr_q;
    issue_w_d  = issue_w_q;
    issue_ok_d = issue_ok_q;
    run_d      = run_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    page0_d    = page0_q;
    end_d      = end_q;
    done_d     = 1'b0;
    res_addr_d = res_addr_q;
    res_ok_d   = res_ok_q;
    bm_rd      = '0;
    bm_wr      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          mode_d  = mode_e'(mode_i);
          want_d  = CNT_W'(page_count_i);
          faddr_d = free_address_i;
          if (mode_e'(mode_i) == MODE_FREE) begin
            state_d = S_FSUB;
          end else if (page_count_i == '0 || limit == '0) begin
            done_d     = 1'b1;
            res_addr_d = '0;
            res_ok_d   = 1'b0;
          end else begin
            issue_w_d  = '0;
            issue_ok_d = 1'b1;
            run_d      = '0;
            state_d    = S_SCAN;
          end
        end
      end

      // One word read per cycle; the word read last cycle is scanned now.
      S_SCAN: begin
        if (issue_ok_q) begin
          bm_rd.en   = 1'b1;
          bm_rd.addr = issue_w_q;
          issue_w_d  = issue_w_q + WADDR_W'(1);
          issue_ok_d = (issue_w_q != last_w);
        end
        if (rd_ok_q) begin
          if (scan_res.hit) begin
            lo_d    = hit_start;
            hi_d    = LIM_W'(hit_page) + LIM_W'(1);
            state_d = S_WSTART;
          end else if (rd_w_q == last_w) begin
            done_d     = 1'b1;
            res_addr_d = '0;
            res_ok_d   = 1'b0;
            state_d    = S_IDLE;
          end else begin
            run_d = scan_res.run_out;
          end
        end
      end

      S_WSTART: begin
        bm_rd.en   = 1'b1;
        bm_rd.addr = lo_word;
        state_d    = S_WALK;
      end

      // Read-modify-write of each word of the range, one word per cycle.
      S_WALK: begin
        bm_wr.en   = 1'b1;
        bm_wr.addr = rd_w_q;
        bm_wr.data = (mode_q == MODE_ALLOC) ? (bm_rdata | walk_mask)
                                            : (bm_rdata & ~walk_mask);
        if (rd_w_q == hi_word) begin
          done_d   = 1'b1;
          res_ok_d = 1'b1;
          if (mode_q == MODE_ALLOC) begin
            res_addr_d = heap_base_q + (ADDR_W'(lo_q) << PB_SH);
          end else begin
            res_addr_d = '0;
          end
          state_d = S_IDLE;
        end else begin
          bm_rd.en   = 1'b1;
          bm_rd.addr = rd_w_q + WADDR_W'(1);
        end
      end

      S_FSUB: begin
        page0_d = fdiff[ADDR_W-1:PB_SH];
        state_d = S_FEND;
      end

      S_FEND: begin
        end_d   = {1'b0, page0_q} + (PG_W + 1)'(want_q);
        state_d = S_FCLIP;
      end

      S_FCLIP: begin
        if (clip_lo < clip_hi) begin
          lo_d    = clip_lo[PIDX_W-1:0];
          hi_d    = clip_hi[LIM_W-1:0];
          state_d = S_WSTART;
        end else begin
          done_d     = 1'b1;
          res_addr_d = '0;
          res_ok_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The read issued this cycle returns data next cycle.
  assign rd_ok_d = bm_rd.en;
  assign rd_w_d  = bm_rd.addr;

  bpra_bitmap u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (bm_rd),
    .rd_data_o (bm_rdata),
    .wr_i      (bm_wr)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      issue_ok_q <= 1'b0;
      rd_ok_q    <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      issue_ok_q <= issue_ok_d;
      rd_ok_q    <= rd_ok_d;
      done_q     <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    want_q     <= want_d;
    faddr_q    <= faddr_d;
    issue_w_q  <= issue_w_d;
    run_q      <= run_d;
    rd_w_q     <= rd_w_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    page0_q    <= page0_d;
    end_q      <= end_d;
    res_addr_q <= res_addr_d;
    res_ok_q   <= res_ok_d;
  end

  assign done_o        = done_q;
  assign run_address_o = res_addr_q;
  assign success_o     = res_ok_q;

endmodule

[src/bpra_bitmap.sv]
// Page-used bitmap: a word-wide synchronous RAM with one read and one write port.
// Each row has a valid bit cleared at reset, so an unwritten row reads as all free.
// Depends on bpra_pkg.

module bpra_bitmap
  import bpra_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bm_rd_t               rd_i,
  output logic [WORD_BITS-1:0] rd_data_o,
  input  bm_wr_t               wr_i
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic [NUM_WORDS-1:0] row_vld_q;
  logic                 rd_vld_q;

  // Storage array and registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  // Row valid bits and the valid flag that travels with the read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        row_vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_vld_q <= row_vld_q[rd_i.addr];
      end
    end
  end

  // A row never written holds only free pages.
  assign rd_data_o = rd_vld_q ? rdata_q : '0;

endmodule

[src/bpra_word_scan.sv]
// Run finder for one bitmap word: carries the free run from lower words and
// reports the lowest page where the run reaches the wanted length.
// Depends on bpra_pkg.

module bpra_word_scan
  import bpra_pkg::*;
(
  input  logic [WORD_BITS-1:0] used_i,
  input  logic [CNT_W-1:0]     run_i,
  input  logic [CNT_W-1:0]     want_i,
  output scan_res_t            res_o
);

  logic [WB_W-1:0]  last_used;
  logic             found;
  logic [CNT_W-1:0] run_len;

  // For every bit position, the length of the free run that ends there; the
  // lowest position whose run is long enough wins.
  always_comb begin
    res_o = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      last_used = '0;
      found     = 1'b0;
      for (int k = 0; k < WORD_BITS; k++) begin
        if (k <= j && used_i[k]) begin
          last_used = WB_W'(k);
          found     = 1'b1;
        end
      end
      if (found) begin
        run_len = CNT_W'(j) - CNT_W'(last_used);
      end else begin
        run_len = run_i + CNT_W'(j + 1);
      end
      if (j == WORD_BITS - 1) begin
        res_o.run_out = run_len;
      end
      if (run_len >= want_i) begin
        res_o.hit = 1'b1;
        res_o.pos = WB_W'(j);
      end
    end
  end

endmodule
